[hw/rtl/bitmap_first_fit_allocator_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap first-fit allocator
// Wrappers that give every concurrent check the same clock and reset terms.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bffa_pkg.sv]
// ---------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Sizes, codes, state encoding and the structs passed between the modules.
// ---------------------------------------------------------------------------
package bffa_pkg;

  // Managed region and the digit that the scan consumes per step.
  localparam int NUM_UNITS = 4096;
  localparam int DIGIT_W   = 8;
  localparam int UNIT_W    = $clog2(NUM_UNITS);
  localparam int DIGIT_LOG = $clog2(DIGIT_W);
  localparam int ROWS      = NUM_UNITS / DIGIT_W;
  localparam int ROW_W     = UNIT_W - DIGIT_LOG;
  localparam int RUN_W     = UNIT_W + 1;
  localparam int COUNT_W   = 13;
  localparam int END_W     = ((UNIT_W > COUNT_W) ? UNIT_W : COUNT_W) + 1;
  localparam int ADDR_W    = 32;

  localparam logic [ADDR_W-1:0] REGION_BASE_RESET = 32'd6407964;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_PREP,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESULT
  } bffa_state_t;

  // Control of the run scanner.
  typedef struct packed {
    logic restart;
    logic step;
  } scan_ctl_t;

  // Scanner report for the digit at hand.
  typedef struct packed {
    logic              found;
    logic [UNIT_W-1:0] start;
  } scan_hit_t;

  // Bitmap memory access.
  typedef struct packed {
    logic               we;
    logic [ROW_W-1:0]   waddr;
    logic [DIGIT_W-1:0] wdata;
    logic               re;
    logic [ROW_W-1:0]   raddr;
  } ram_req_t;

endpackage

[hw/rtl/bffa_req_if.sv]
// ---------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one allocate or free request per beat.
// ---------------------------------------------------------------------------
interface bffa_req_if import bffa_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COUNT_W-1:0] unit_count;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, output kind, output unit_count, output free_address,
                  input ready);
  modport sink   (input valid, input kind, input unit_count, input free_address,
                  output ready);
endinterface

[hw/rtl/bffa_rsp_if.sv]
// ---------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one status and run address per beat.
// ---------------------------------------------------------------------------
interface bffa_rsp_if import bffa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              status;
  logic [ADDR_W-1:0] run_address;

  modport source (output valid, output status, output run_address, input ready);
  modport sink   (input valid, input status, input run_address, output ready);
endinterface

[hw/rtl/bffa_map_ram.sv]
// ---------------------------------------------------------------------------
// Allocation bitmap memory
// One row per digit of units, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bffa_map_ram import bffa_pkg::*; (
  input  logic               clk,
  input  ram_req_t           req,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [ROWS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[hw/rtl/bffa_run_scan.sv]
// ---------------------------------------------------------------------------
// Free-run scanner
// Consumes one bitmap digit per step and tracks the current run of free units.
// ---------------------------------------------------------------------------
module bffa_run_scan import bffa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  logic [ROW_W-1:0]   row,
  input  logic [DIGIT_W-1:0] digit,
  input  logic [COUNT_W-1:0] want,
  output scan_hit_t          hit
);

  logic [RUN_W-1:0] run;
  logic [RUN_W-1:0] run_next;

  // Walk the bits of the digit from the lowest unit upward.
  always_comb begin
    logic [RUN_W-1:0]  r;
    logic [UNIT_W-1:0] u;
    r         = run;
    u         = '0;
    hit.found = 1'b0;
    hit.start = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      u = {row, DIGIT_LOG'(i)};
      if (digit[i]) begin
        r = '0;
      end else begin
        r = r + RUN_W'(1);
      end
      if (!hit.found && !digit[i] && (END_W'(r) == END_W'(want))) begin
        hit.found = 1'b1;
        hit.start = u + UNIT_W'(1) - r[UNIT_W-1:0];
      end
    end
    run_next = r;
  end

  // Run length carried from one digit to the next.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      run <= '0;
    end else if (ctl.step) begin
      run <= run_next;
    end
  end

endmodule

[hw/rtl/bitmap_first_fit_allocator_unit.sv]
// ---------------------------------------------------------------------------
// Bitmap first-fit allocator
// Allocates and frees runs of units in a bitmap, scanning one digit per step.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  req     | in        | valid / ready    | kind, unit_count, free_address
//  rsp     | out       | valid / ready    | status, run_address
//  cfg     | in        | cfg_wr_en        | cfg_wr_data (region_base)
//
// An allocate reads and evaluates each bitmap row in turn (8 units a row, up
// to 512 rows), then reads and writes back each row touched when the run is
// marked; the bitmap memory's single read port sets this pace. A free reads
// and writes back each row cleared. After reset the block wipes every row of
// the bitmap before it takes a request. A request is taken while an earlier result
// still waits on rsp; the block then holds the new result until rsp is free.
module bitmap_first_fit_allocator_unit import bffa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bffa_req_if.sink          req,
  bffa_rsp_if.source        rsp,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data
);

`include "bitmap_first_fit_allocator_unit_macros.svh"

  bffa_state_t        state;
  bffa_state_t        state_next;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  region_base;
  logic               kind_q;
  logic [COUNT_W-1:0] count_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [UNIT_W-1:0]  span_start;
  logic [END_W-1:0]   span_end;
  logic               set_mode;
  logic               res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic               out_valid;
  logic               out_status;
  logic [ADDR_W-1:0]  out_addr;

  ram_req_t           ram_req;
  logic [DIGIT_W-1:0] ram_rdata;
  scan_ctl_t          scan_ctl;
  scan_hit_t          scan_hit;

  logic               in_fire;
  logic               out_free;
  logic [ADDR_W-1:0]  free_offset;
  logic               offset_in_map;
  logic               last_row;
  logic [END_W-1:0]   row_base;
  logic [END_W-1:0]   next_base;
  logic               span_done;
  logic [DIGIT_W-1:0] span_mask;
  logic [DIGIT_W-1:0] row_update;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign last_row = (row == ROW_W'(ROWS - 1));

  // Offset of a freed run inside the map, wrapping below the base.
  assign free_offset   = addr_q - region_base;
  assign offset_in_map = (free_offset < ADDR_W'(NUM_UNITS));

  // Span limits for the mark or clear pass.
  assign row_base  = END_W'({row, DIGIT_LOG'(0)});
  assign next_base = row_base + END_W'(DIGIT_W);
  assign span_done = last_row || (next_base >= span_end);

  // Units of the current row that fall inside the span.
  always_comb begin
    logic [END_W-1:0] u;
    u = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      u            = END_W'({row, DIGIT_LOG'(i)});
      span_mask[i] = (u >= END_W'(span_start)) && (u < span_end);
    end
  end

  assign row_update = set_mode ? (ram_rdata | span_mask) : (ram_rdata & ~span_mask);

  bffa_map_ram u_map_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  bffa_run_scan u_run_scan (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .row   (row),
    .digit (ram_rdata),
    .want  (count_q),
    .hit   (scan_hit)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE: begin
        if (last_row) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (count_q == '0) begin
          state_next = ST_RESULT;
        end else if (kind_q == KIND_ALLOC) begin
          state_next = ST_SCAN_RD;
        end else if (offset_in_map) begin
          state_next = ST_MARK_RD;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (scan_hit.found) begin
          state_next = ST_MARK_RD;
        end else if (last_row) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_MARK_RD: state_next = ST_MARK_WR;
      ST_MARK_WR: begin
        if (span_done) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_MARK_RD;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_WIPE;
    endcase
  end

  // Outputs of the state machine: memory access, scanner control, ready.
  always_comb begin
    ram_req.we       = 1'b0;
    ram_req.waddr    = row;
    ram_req.wdata    = row_update;
    ram_req.re       = 1'b0;
    ram_req.raddr    = row;
    scan_ctl.restart = 1'b0;
    scan_ctl.step    = 1'b0;
    req.ready        = 1'b0;
    unique case (state)
      ST_WIPE: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '0;
      end
      ST_IDLE:    req.ready        = 1'b1;
      ST_PREP:    scan_ctl.restart = 1'b1;
      ST_SCAN_RD: ram_req.re       = 1'b1;
      ST_SCAN_EV: scan_ctl.step    = 1'b1;
      ST_MARK_RD: ram_req.re       = 1'b1;
      ST_MARK_WR: ram_req.we       = 1'b1;
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Row pointer: wipe sweep, scan position and span position.
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      case (state)
        ST_WIPE: row <= row + ROW_W'(1);
        ST_PREP: begin
          if (kind_q == KIND_ALLOC) begin
            row <= '0;
          end else begin
            row <= free_offset[UNIT_W-1:DIGIT_LOG];
          end
        end
        ST_SCAN_EV: begin
          if (scan_hit.found) begin
            row <= scan_hit.start[UNIT_W-1:DIGIT_LOG];
          end else if (!last_row) begin
            row <= row + ROW_W'(1);
          end
        end
        ST_MARK_WR: begin
          if (!span_done) begin
            row <= row + ROW_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Region base register.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RESET;
    end else if (cfg_wr_en) begin
      region_base <= cfg_wr_data;
    end
  end

  // Request fields, span limits and the pending result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q  <= req.kind;
      count_q <= req.unit_count;
      addr_q  <= req.free_address;
    end
    case (state)
      ST_PREP: begin
        span_start <= free_offset[UNIT_W-1:0];
        span_end   <= END_W'(free_offset[UNIT_W-1:0]) + END_W'(count_q);
        set_mode   <= 1'b0;
        res_addr   <= '0;
        res_status <= (kind_q == KIND_ALLOC) ? STATUS_NO_SPACE : STATUS_OK;
      end
      ST_SCAN_EV: begin
        if (scan_hit.found) begin
          span_start <= scan_hit.start;
          span_end   <= END_W'(scan_hit.start) + END_W'(count_q);
          set_mode   <= 1'b1;
          res_status <= STATUS_OK;
          res_addr   <= region_base + ADDR_W'(scan_hit.start);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register toward the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.run_address = out_addr;

  // Checks.
  `BFFA_ASSERT_NEXT(a_accept_starts_work, in_fire, state == ST_PREP, "accepted beat did not start work")
  `BFFA_ASSERT_SAME(a_fail_addr_zero, rsp.valid && rsp.status == STATUS_NO_SPACE, rsp.run_address == '0, "failed allocation carries an address")
  `BFFA_ASSERT_SAME(a_mark_row_in_span, state == ST_MARK_WR, row_base < span_end, "mark pass runs past the span end")
  `BFFA_ASSERT_SAME(a_scan_nonzero_size, state == ST_SCAN_EV, count_q != '0, "scan started for a zero-size request")

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// Testbench for the bitmap first-fit allocator
// Drives allocate and free requests through the request channel with random
// gaps and result stalls. A scoreboard keeps its own copy of the allocation
// bitmap and the region base, works out each expected result and compares
// it with the result beats in order. The region base is rewritten between
// phases, including both extremes.
// ---------------------------------------------------------------------------
module testbench import bffa_pkg::*;;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] run_address;
  } run_result_t;

  // Bitmap predictor plus the queue of results still owed by the block.
  class alloc_scoreboard;
    bit                in_use [NUM_UNITS];
    bit [ADDR_W-1:0]   region_base;
    run_result_t       expected_results [$];
    int                failures;
    int                allocs;
    int                grants;
    int                frees;

    function new();
      foreach (in_use[u]) in_use[u] = 1'b0;
      region_base = REGION_BASE_RESET;
    endfunction

    // First run of free units exactly as long as the request, from unit 0 up.
    function run_result_t grant_run(int unsigned want);
      int unsigned run_len;
      int unsigned first;
      run_result_t res;
      run_len = 0;
      res.status = STATUS_NO_SPACE;
      res.run_address = '0;
      if (want != 0) begin
        for (int u = 0; u < NUM_UNITS; u++) begin
          if (in_use[u]) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == want) begin
              first = u + 1 - run_len;
              for (int k = first; k <= u; k++) in_use[k] = 1'b1;
              res.status = STATUS_OK;
              res.run_address = region_base + first;
              break;
            end
          end
        end
      end
      return res;
    endfunction

    // Units past the end are dropped; an address below the base lands there too.
    function void release_run(bit [ADDR_W-1:0] addr, int unsigned count);
      bit [ADDR_W-1:0] offset;
      longint unsigned u;
      offset = addr - region_base;
      if (offset < NUM_UNITS) begin
        for (longint unsigned k = 0; k < count; k++) begin
          u = longint'(offset) + k;
          if (u < NUM_UNITS) in_use[u] = 1'b0;
        end
      end
    endfunction

    function run_result_t note_request(logic kind, int unsigned count,
                                       logic [ADDR_W-1:0] addr);
      run_result_t res;
      if (kind == KIND_ALLOC) begin
        allocs++;
        res = grant_run(count);
        if (res.status == STATUS_OK) grants++;
      end else begin
        frees++;
        release_run(addr, count);
        res.status = STATUS_OK;
        res.run_address = '0;
      end
      expected_results.push_back(res);
      return res;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      failures++;
    endtask

    task check_result(logic status, logic [ADDR_W-1:0] addr);
      run_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, status %0b address %h",
                                  status, addr));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", status, want.status));
        if (addr !== want.run_address)
          report_mismatch($sformatf("run address %h, expected %h", addr,
                                    want.run_address));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;
  bit                calm = 1'b0;

  alloc_scoreboard   ledger = new();

  // Runs currently held by the stimulus, as unit offsets and lengths.
  int unsigned       live_start [$];
  int unsigned       live_len [$];

  bffa_req_if req_ch ();
  bffa_rsp_if rsp_ch ();

  bitmap_first_fit_allocator_unit uut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Clock with a 12-unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side stalls at random, except during a calm stretch.
  always @(posedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      ledger.check_result(rsp_ch.status, rsp_ch.run_address);
  end

  // Sends one request beat after an optional random gap.
  task automatic request(input logic kind, input int unsigned count,
                         input logic [ADDR_W-1:0] addr, output run_result_t res);
    while (!calm && $urandom_range(0, 99) < 34) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.unit_count   <= COUNT_W'(count);
    req_ch.free_address <= addr;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    res = ledger.note_request(kind, count, addr);
  endtask

  // Stops sending and waits until every owed result has been seen.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (ledger.expected_results.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ledger.region_base = value;
  endtask

  // Edge cases at the default base: empty, full, fragmented, out of range.
  task automatic directed_checks();
    logic [ADDR_W-1:0] b;
    run_result_t res;
    b = ledger.region_base;
    request(KIND_ALLOC, 0, '0, res);
    request(KIND_ALLOC, 1, '1, res);
    request(KIND_ALLOC, 8, '0, res);
    request(KIND_ALLOC, NUM_UNITS, '0, res);
    request(KIND_FREE, NUM_UNITS, b, res);
    request(KIND_ALLOC, NUM_UNITS, '0, res);
    request(KIND_ALLOC, 1, '0, res);
    // An address below the base wraps to a huge offset and clears nothing.
    request(KIND_FREE, 5, b - 1, res);
    request(KIND_ALLOC, 1, '0, res);
    // Freeing across the end only touches the last units.
    request(KIND_FREE, 100, b + NUM_UNITS - 6, res);
    request(KIND_ALLOC, 6, '0, res);
    request(KIND_ALLOC, 7, '0, res);
    // Two holes: a short one first, then a longer one further up.
    request(KIND_FREE, 2, b + 20, res);
    request(KIND_FREE, 5, b + 30, res);
    request(KIND_ALLOC, 3, '0, res);
    request(KIND_ALLOC, 2, '0, res);
    request(KIND_FREE, 2, b + 20, res);
    request(KIND_FREE, 2, b + 20, res);
    request(KIND_FREE, NUM_UNITS, 32'hFFFF_FFFF, res);
    request(KIND_FREE, 0, '0, res);
    request(KIND_FREE, NUM_UNITS, b, res);
  endtask

  // Mostly allocations and frees of held runs, with some noise mixed in.
  task automatic random_traffic(int n);
    int unsigned roll;
    int unsigned idx;
    logic kind;
    int unsigned count;
    logic [ADDR_W-1:0] addr;
    run_result_t res;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      addr = $urandom;
      if (roll < 10) begin
        case ($urandom_range(0, 3))
          0: begin
            kind  = KIND_ALLOC;
            count = $urandom_range(0, NUM_UNITS);
          end
          1: begin
            kind  = KIND_FREE;
            count = $urandom_range(0, NUM_UNITS);
          end
          2: begin
            kind  = KIND_FREE;
            count = $urandom_range(0, 64);
            addr  = ledger.region_base + $urandom_range(0, NUM_UNITS - 1);
          end
          default: begin
            kind  = KIND_ALLOC;
            count = 0;
          end
        endcase
      end else if (live_start.size() > 0 && (roll < 45 || live_start.size() > 48)) begin
        idx   = $urandom_range(0, live_start.size() - 1);
        kind  = KIND_FREE;
        count = live_len[idx];
        addr  = ledger.region_base + live_start[idx];
        live_start.delete(idx);
        live_len.delete(idx);
      end else begin
        kind = KIND_ALLOC;
        roll = $urandom_range(0, 99);
        if (roll < 85) count = $urandom_range(1, 16);
        else if (roll < 97) count = $urandom_range(17, 256);
        else count = $urandom_range(257, NUM_UNITS);
      end
      request(kind, count, addr, res);
      if (kind == KIND_ALLOC && res.status == STATUS_OK) begin
        live_start.push_back(res.run_address - ledger.region_base);
        live_len.push_back(count);
      end
    end
  endtask

  // Main sequence: reset, directed checks, then random phases per base.
  initial begin
    logic [ADDR_W-1:0] bases [4];
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_ALLOC;
    req_ch.unit_count   = '0;
    req_ch.free_address = '0;
    bases = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'hFFFF_F000};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    for (int p = 0; p < 4; p++) begin
      settle();
      write_base(bases[p]);
      calm = (p == 2);
      random_traffic(95);
    end
    calm = 1'b0;
    settle();
    $display("Covered %0d allocations (%0d granted) and %0d frees over four region bases,",
             ledger.allocs, ledger.grants, ledger.frees);
    $display("with random gaps on requests and stalls on results.");
    if (ledger.failures == 0 && ledger.expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #60000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
